// ----- src/slipd_pkg.sv -----
`timescale 1ns / 1ps

package slipd_pkg;

  // SLIP special characters
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [15:0] MIN_LEN_RESET = 16'd20;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1500;
  localparam logic [15:0] LEN_SAT       = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_RUNT     = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] min_len;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] length;
  } res_t;

endpackage

// ----- src/slip_frame_decoder.sv -----
`timescale 1ns / 1ps

// SLIP receive deframer.
// s_axis carries raw line bytes, one word per byte. m_axis carries results:
// tuser gives the kind (data, frame good, runt dropped, overflow dropped),
// tdata gives the decoded byte (zero unless kind is data) and the frame
// length (running count for data words, final count otherwise).
// ESC (0xDB) produces no word; an END with an empty frame produces none.
// Min/max frame length live on the APB port at 0x0 and 0x4; write them only
// while the block is idle.
// Path: a byte taken from s_axis goes into the input register, is decoded out
// of it into the output register, and its word is then on m_axis.
// Throughput: one byte per cycle, set by the single decode step between the
// input register and the output register (escape flag plus 16-bit counter).
// When m_axis stalls, the output register holds its word and the input
// register still takes one more byte; s_axis_tready then drops until the
// output drains. Bytes that give no word also wait for the output to drain.
// Reset (rst, synchronous) empties both registers, clears the escape flag
// and the byte count, and restores min 20 / max 1500.

module slip_frame_decoder import slipd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // line input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  // decoded output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] frame_length
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  res_t res;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  // output register
  logic       out_valid;
  res_t       out_res;

  logic out_free, advance;

  slipd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slipd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .line_byte (in_byte),
    .cfg       (cfg),
    .res       (res)
  );

  // output register can take a new word when empty or draining this cycle
  assign out_free      = !out_valid || m_axis_tready;
  // a byte leaving the input register commits the decode state
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.length, out_res.data};
  assign m_axis_tuser  = out_res.kind;

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:8] != 16'd0)
    else $error("result with zero frame length");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_DATA |-> m_axis_tdata[7:0] == 8'd0)
    else $error("non-data word carries a data byte");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |-> !s_axis_tready && !advance)
    else $error("input advanced into a stalled output");

endmodule

// ----- src/slipd_cfg.sv -----
`timescale 1ns / 1ps

module slipd_cfg import slipd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_len <= MIN_LEN_RESET;
      cfg.max_len <= MAX_LEN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MIN_LEN: cfg.min_len <= pwdata[15:0];
        REG_MAX_LEN: cfg.max_len <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_LEN: prdata = {16'd0, cfg.min_len};
      REG_MAX_LEN: prdata = {16'd0, cfg.max_len};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/slipd_decode.sv -----
`timescale 1ns / 1ps

module slipd_decode import slipd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] line_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  logic        escape_pending, escape_pending_next;
  logic [15:0] byte_count, byte_count_next;
  logic        is_payload, is_end;
  logic [7:0]  payload;
  logic [16:0] count_inc;

  assign count_inc = {1'b0, byte_count} + 17'd1;

  always_comb begin
    escape_pending_next = 1'b0;
    is_payload = 1'b0;
    is_end     = 1'b0;
    payload    = line_byte;
    if (escape_pending) begin
      if (line_byte == SLIP_ESC_END) begin
        is_payload = 1'b1;
        payload    = SLIP_END;
      end else if (line_byte == SLIP_ESC_ESC) begin
        is_payload = 1'b1;
        payload    = SLIP_ESC;
      end else begin
        // anything else after ESC closes the frame
        is_end = 1'b1;
      end
    end else if (line_byte == SLIP_END) begin
      is_end = 1'b1;
    end else if (line_byte == SLIP_ESC) begin
      escape_pending_next = 1'b1;
    end else begin
      is_payload = 1'b1;
    end
  end

  always_comb begin
    res             = '0;
    res.kind        = KIND_DATA;
    byte_count_next = byte_count;
    if (is_payload) begin
      res.valid = 1'b1;
      if (count_inc > {1'b0, cfg.max_len}) begin
        res.kind        = KIND_OVERFLOW;
        res.length      = count_inc[16] ? LEN_SAT : count_inc[15:0];
        byte_count_next = 16'd0;
      end else begin
        res.data        = payload;
        res.length      = count_inc[15:0];
        byte_count_next = count_inc[15:0];
      end
    end else if (is_end && byte_count != 16'd0) begin
      res.valid       = 1'b1;
      res.kind        = (byte_count < cfg.min_len) ? KIND_RUNT : KIND_GOOD;
      res.length      = byte_count;
      byte_count_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      byte_count     <= 16'd0;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
    end
  end

  a_esc_sets_pending: assert property (@(posedge clk) disable iff (rst)
    advance && !escape_pending && line_byte == SLIP_ESC |=> escape_pending)
    else $error("ESC did not set escape_pending");

  a_close_clears_count: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid && res.kind != KIND_DATA |=> byte_count == 16'd0)
    else $error("count not cleared after frame close");

  a_no_result_on_esc: assert property (@(posedge clk) disable iff (rst)
    !escape_pending && line_byte == SLIP_ESC |-> !res.valid)
    else $error("ESC byte produced a result");

endmodule

// ----- verif/slip_frame_decoder_tb.sv -----
`timescale 1ns / 1ps

// SLIP deframer check: line bytes go in on s_axis, every word out of m_axis
// is compared with a local decoder model, and the limits are rewritten over
// APB between phases while the block is idle.

module slip_frame_decoder_tb;
  import slipd_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_GUARD  = 200;   // cycles allowed for the last words
  localparam int SETTLE_WAIT  = 6;     // two-stage pipe plus margin

  // one decoded word as seen on m_axis
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] len;
  } decoded_word_t;

  logic        clk;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] line_byte

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;            // [7:0] data_byte, [23:8] frame_length
  logic [1:0]  m_axis_tuser;            // [1:0] result_kind

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  slip_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Decoder model: escape flag, frame counter and the two length limits.
  // The limits only change while the block is idle.
  // ---------------------------------------------------------------------
  bit            esc_seen = 1'b0;
  int            frame_count = 0;
  int            min_len_cfg = MIN_LEN_RESET;
  int            max_len_cfg = MAX_LEN_RESET;

  logic [7:0]    line_bytes[$];       // bytes waiting to go out on s_axis
  decoded_word_t expected_words[$];   // predicted words not yet seen
  decoded_word_t predicted;
  decoded_word_t want;

  int  errors = 0;
  int  line_count = 0;
  int  kind_count[4] = '{0, 0, 0, 0};
  int  settings = 0;
  bit  throttle = 1'b0;               // random gaps and stalls on both sides
  int  gap_left = 0;
  int  rdy_wait = 0;
  int  rdy_draw = 0;
  int  cycles = 0;

  function automatic bit decode_line_byte(input logic [7:0] b, output decoded_word_t w);
    logic [7:0] payload;
    bit         closes;
    int         next;
    w = '{KIND_DATA, 8'h00, 16'h0000};
    payload = b;
    closes = 1'b0;
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == SLIP_ESC_END) payload = SLIP_END;
      else if (b == SLIP_ESC_ESC) payload = SLIP_ESC;
      else closes = 1'b1;             // stray byte after ESC acts as END
    end else if (b == SLIP_END) begin
      closes = 1'b1;
    end else if (b == SLIP_ESC) begin
      esc_seen = 1'b1;
      return 1'b0;
    end
    if (closes) begin
      if (frame_count == 0) return 1'b0;   // empty frame: nothing reported
      w.kind = (frame_count < min_len_cfg) ? KIND_RUNT : KIND_GOOD;
      w.len = 16'(frame_count);
      frame_count = 0;
      return 1'b1;
    end
    next = frame_count + 1;
    if (next > max_len_cfg) begin
      // the byte that overflows is swallowed; count restarts
      frame_count = 0;
      w.kind = KIND_OVERFLOW;
      w.len = (next > 65535) ? LEN_SAT : 16'(next);
      return 1'b1;
    end
    frame_count = next;
    w.data = payload;
    w.len = 16'(next);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Line-side driver: one byte per word, optional gap after each byte.
  // Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_line_byte(s_axis_tdata, predicted)) expected_words.push_back(predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (line_bytes.size() != 0) begin
          s_axis_tdata <= line_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          gap_left <= throttle ? int'($urandom_range(9, 0)) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result-side monitor: compares each word with the oldest prediction and,
  // when throttled, may hold tready low for a random wait after each word.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      rdy_wait <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with nothing expected: kind %0d data %02h length %0d",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
          errors++;
        end else begin
          want = expected_words.pop_front();
          kind_count[want.kind]++;
          if (m_axis_tuser !== want.kind) begin
            $display("%0t: result_kind expected %0d got %0d", $time, want.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[7:0] !== want.data) begin
            $display("%0t: data_byte expected %02h got %02h", $time, want.data,
                     m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[23:8] !== want.len) begin
            $display("%0t: frame_length expected %0d got %0d", $time, want.len,
                     m_axis_tdata[23:8]);
            errors++;
          end
        end
        // a draw of zero keeps tready high for the next word
        rdy_draw = throttle ? int'($urandom_range(9, 0)) : 0;
        rdy_wait <= rdy_draw;
        m_axis_tready <= (rdy_draw == 0);
      end else if (!m_axis_tready) begin
        if (rdy_wait > 1) rdy_wait <= rdy_wait - 1;
        else m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    line_bytes.push_back(b);
    line_count++;
  endtask

  // payload bytes escaped as on the wire, then END or a stray-escape end
  task automatic push_frame(input int n);
    logic [7:0] b;
    repeat (n) begin
      if ($urandom_range(99, 0) < 15) begin
        case ($urandom_range(3, 0))
          0:       b = SLIP_END;
          1:       b = SLIP_ESC;
          2:       b = SLIP_ESC_END;
          default: b = SLIP_ESC_ESC;
        endcase
      end else begin
        b = 8'($urandom_range(255, 0));
      end
      if (b == SLIP_END) begin
        put_byte(SLIP_ESC);
        put_byte(SLIP_ESC_END);
      end else if (b == SLIP_ESC) begin
        put_byte(SLIP_ESC);
        put_byte(SLIP_ESC_ESC);
      end else begin
        put_byte(b);
      end
    end
    if ($urandom_range(9, 0) < 8) begin
      put_byte(SLIP_END);
    end else begin
      do b = 8'($urandom_range(255, 0));
      while (b == SLIP_ESC_END || b == SLIP_ESC_ESC);
      put_byte(SLIP_ESC);
      put_byte(b);
    end
  endtask

  // raw line noise, heavy on bare END and ESC
  task automatic push_noise(input int n);
    repeat (n) begin
      case ($urandom_range(2, 0))
        0:       put_byte(SLIP_END);
        1:       put_byte(SLIP_ESC);
        default: put_byte(8'($urandom_range(255, 0)));
      endcase
    end
  endtask

  // long frame of plain bytes, no escaping needed
  task automatic push_plain(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255, 0));
      if (b == SLIP_END || b == SLIP_ESC) b = b ^ 8'h01;
      put_byte(b);
    end
  endtask

  // wait for the line queue and all predicted words, then let the pipe empty
  task automatic settle();
    int guard;
    guard = 0;
    while (line_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_words.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived, next kind %0d length %0d",
               $time, expected_words.size(), expected_words[0].kind,
               expected_words[0].len);
      errors++;
      expected_words.delete();
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_read(input logic reg_idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'h0000, val}) begin
      $display("%0t: register %0d readback expected %08h got %08h", $time, reg_idx,
               {16'h0000, val}, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);                   // register takes the value here
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_MIN_LEN) min_len_cfg = val;
    else max_len_cfg = val;
    cfg_read(reg_idx, val);
  endtask

  task automatic set_limits(input int min_v, input int max_v);
    settle();
    cfg_write(REG_MIN_LEN, 16'(min_v));
    cfg_write(REG_MAX_LEN, 16'(max_v));
    settings++;
  endtask

  // frame length biased towards both limits
  function automatic int pick_frame_len();
    int c;
    int n;
    case ($urandom_range(4, 0))
      0: n = $urandom_range(3, 0);
      1: begin
        c = (min_len_cfg > 70) ? 70 : min_len_cfg;
        n = c + int'($urandom_range(4, 0)) - 2;
      end
      2: begin
        c = (max_len_cfg > 70) ? 70 : max_len_cfg;
        n = c + int'($urandom_range(4, 0)) - 2;
      end
      default: n = $urandom_range(40, 0);
    endcase
    return (n < 0) ? 0 : n;
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int random_start;
    int target;
    int min_v;
    int max_v;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // limits come up at their reset values
    cfg_read(REG_MIN_LEN, MIN_LEN_RESET);
    cfg_read(REG_MAX_LEN, MAX_LEN_RESET);
    settings++;

    // reset limits: empty end, both escapes, byte extremes, runt,
    // stray byte after ESC with and without payload, ESC left hanging
    put_byte(SLIP_END);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(SLIP_ESC);
    put_byte(SLIP_ESC_END);
    put_byte(SLIP_ESC);
    put_byte(SLIP_ESC_ESC);
    put_byte(8'h55);
    put_byte(8'hAA);
    put_byte(SLIP_END);
    put_byte(SLIP_ESC);
    put_byte(8'h41);
    put_byte(8'h7F);
    put_byte(SLIP_ESC);
    put_byte(8'h12);
    put_byte(SLIP_ESC);

    // minimum of zero, tiny maximum; escape carried over from last phase
    set_limits(0, 3);
    put_byte(SLIP_ESC_END);
    put_byte(8'h01);
    put_byte(SLIP_END);
    put_byte(8'h01);
    put_byte(8'h02);
    put_byte(8'h03);
    put_byte(8'h04);
    put_byte(8'h05);
    put_byte(SLIP_END);

    // maximum of zero: every payload byte overflows at length 1
    set_limits(65535, 0);
    put_byte(8'h33);
    put_byte(SLIP_ESC);
    put_byte(SLIP_ESC_END);
    put_byte(SLIP_END);

    // both limits at the top: these frames, all below the minimum, are runts
    set_limits(65535, 65535);
    push_plain(20);
    put_byte(SLIP_END);
    push_plain(120);
    put_byte(SLIP_END);

    // random phases with fresh limits each time
    random_start = line_count;
    while (line_count - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(7, 0))
        0:       min_v = 0;
        1:       min_v = 65535;
        default: min_v = $urandom_range(16, 1);
      endcase
      case ($urandom_range(7, 0))
        0:       max_v = 0;
        1:       max_v = 65535;
        2:       max_v = $urandom_range(1500, 100);
        default: max_v = $urandom_range(48, 1);
      endcase
      set_limits(min_v, max_v);
      throttle = ($urandom_range(3, 0) != 0);
      target = line_count + int'($urandom_range(200, 80));
      while (line_count < target) begin
        if ($urandom_range(9, 0) == 0) push_noise($urandom_range(6, 1));
        else push_frame(pick_frame_len());
      end
    end

    settle();

    $display("Sent %0d line bytes under %0d limit settings", line_count, settings);
    $display("Checked words: %0d data, %0d good, %0d runt, %0d overflow",
             kind_count[KIND_DATA], kind_count[KIND_GOOD], kind_count[KIND_RUNT],
             kind_count[KIND_OVERFLOW]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
